@@ sv/otm_pkg.sv @@
// ----------------------------------------------------------------------------
// otm_pkg: observed transition matrix shared definitions
// Widths, opcodes, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package otm_pkg;

  localparam int OBS_BITS   = 4;
  localparam int NODE_BITS  = 64;
  localparam int COUNT_BITS = 32;
  localparam int TIME_BITS  = 48;

  localparam int SIDE      = 1 << OBS_BITS;
  localparam int CELLS     = SIDE * SIDE;
  localparam int CELL_BITS = 2 * OBS_BITS;
  localparam int OBS_CW    = (OBS_BITS > 1) ? $clog2(OBS_BITS) : 1;

  localparam int CFG_BITS     = 64;
  localparam int CFG_IDX_BITS = 2;

  localparam int OP_BITS       = 3;
  localparam int IN_DATA_BITS  = 200;
  localparam int OUT_DATA_BITS = 136;
  localparam int OUT_USED_BITS = OBS_BITS + COUNT_BITS + 2 * TIME_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_STATE_MASK    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_COUNT    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_DURATION = 2'd2;

  localparam logic [OP_BITS-1:0] OP_CLEAR = 3'd0;
  localparam logic [OP_BITS-1:0] OP_START = 3'd1;
  localparam logic [OP_BITS-1:0] OP_STEP  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_MERGE = 3'd3;
  localparam logic [OP_BITS-1:0] OP_READ  = 3'd4;

  typedef struct packed {
    logic capture;
    logic clear;
    logic obs_step;
    logic start_set;
    logic step_set;
    logic addr_set;
    logic mem_rd;
    logic modify;
    logic div_start;
    logic out_load;
  } otm_cmd_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               obs_last;
    logic               changed;
    logic               cnt_zero;
    logic               div_busy;
    logic               out_free;
  } otm_stat_t;

endpackage

@@ sv/otm_div.sv @@
// ----------------------------------------------------------------------------
// otm_div: restoring divider
// One quotient bit per cycle; duration divided by count.
// ----------------------------------------------------------------------------
module otm_div
  import otm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [TIME_BITS-1:0]  dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  busy,
  output logic [TIME_BITS-1:0]  quotient
);

  localparam int CW = $clog2(TIME_BITS + 1);

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0]  q_r, q_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] dvs_r;
  logic [COUNT_BITS:0]   shift;
  logic [COUNT_BITS+1:0] diff;
  logic                  ge;

  assign shift = {rem_r, q_r[TIME_BITS-1]};
  assign diff  = {1'b0, shift} - {2'b00, dvs_r};
  assign ge    = ~diff[COUNT_BITS+1];

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CW'(TIME_BITS);
      q_nxt   = dividend;
      rem_nxt = '0;
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      q_nxt   = {q_r[TIME_BITS-2:0], ge};
      rem_nxt = ge ? diff[COUNT_BITS-1:0] : shift[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = q_r;

endmodule

@@ sv/otm_dp.sv @@
// ----------------------------------------------------------------------------
// otm_dp: observed transition matrix datapath
// Config registers, mask extraction, entry memories, saturating update,
// divider and output register.
// ----------------------------------------------------------------------------
module otm_dp
  import otm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  otm_cmd_t                 cmd,
  output otm_stat_t                stat,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  input  logic [OP_BITS-1:0]       in_tuser,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_wdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic [0:0]               out_tuser
);

  logic [NODE_BITS-1:0]  mask_r;
  logic [COUNT_BITS-1:0] init_cnt_r;
  logic [TIME_BITS-1:0]  init_dur_r;

  logic [OP_BITS-1:0]    op_r;
  logic [NODE_BITS-1:0]  net_r;
  logic [TIME_BITS-1:0]  now_r;
  logic [OBS_BITS-1:0]   oi_r, di_r;
  logic [COUNT_BITS-1:0] add_cnt_r;
  logic [TIME_BITS-1:0]  add_dur_r;

  logic [NODE_BITS-1:0]  mask_w_r;
  logic [OBS_BITS-1:0]   cur_idx_r;
  logic [OBS_CW-1:0]     obs_cnt_r;
  logic [OBS_BITS-1:0]   prev_idx_r;
  logic [TIME_BITS-1:0]  prev_time_r;
  logic [CELL_BITS-1:0]  addr_r;

  logic [COUNT_BITS-1:0] fill_cnt_r;
  logic [TIME_BITS-1:0]  fill_dur_r;
  logic [CELLS-1:0]      valid_r;
  logic [COUNT_BITS-1:0] mem_cnt [CELLS];
  logic [TIME_BITS-1:0]  mem_dur [CELLS];
  logic [COUNT_BITS-1:0] rd_cnt_r;
  logic [TIME_BITS-1:0]  rd_dur_r;
  logic                  rd_vld_r;

  logic                  rec_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [TIME_BITS-1:0]  tot_r;

  logic                     out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r;
  logic                     out_user_r;

  logic [NODE_BITS-1:0]  low_bit;
  logic                  obs_bit;
  logic [TIME_BITS-1:0]  dt;
  logic [COUNT_BITS-1:0] ent_cnt, new_cnt, res_cnt;
  logic [TIME_BITS-1:0]  ent_dur, new_dur, res_dur;
  logic [COUNT_BITS:0]   sum_cnt;
  logic [TIME_BITS:0]    sum_dur;
  logic                  wr_en;
  logic                  div_busy;
  logic [TIME_BITS-1:0]  div_q;
  logic [TIME_BITS-1:0]  mean;

  // lowest remaining mask bit picks the next observed network bit
  assign low_bit = mask_w_r & (~mask_w_r + 1'b1);
  assign obs_bit = |(net_r & low_bit);

  assign dt = (now_r > prev_time_r) ? (now_r - prev_time_r) : '0;

  always_comb begin
    ent_cnt = rd_vld_r ? rd_cnt_r : fill_cnt_r;
    ent_dur = rd_vld_r ? rd_dur_r : fill_dur_r;
    sum_cnt = {1'b0, ent_cnt} + {1'b0, add_cnt_r};
    sum_dur = {1'b0, ent_dur} + {1'b0, add_dur_r};
    new_cnt = sum_cnt[COUNT_BITS] ? '1 : sum_cnt[COUNT_BITS-1:0];
    new_dur = sum_dur[TIME_BITS] ? '1 : sum_dur[TIME_BITS-1:0];
    wr_en   = (op_r != OP_READ);
    res_cnt = wr_en ? new_cnt : ent_cnt;
    res_dur = wr_en ? new_dur : ent_dur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r     <= '0;
      init_cnt_r <= '0;
      init_dur_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STATE_MASK:    mask_r     <= cfg_wdata[NODE_BITS-1:0];
        CFG_INIT_COUNT:    init_cnt_r <= cfg_wdata[COUNT_BITS-1:0];
        CFG_INIT_DURATION: init_dur_r <= cfg_wdata[TIME_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // control-side state: valid bits, fill values, observed history, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      fill_cnt_r  <= '0;
      fill_dur_r  <= '0;
      prev_idx_r  <= '0;
      prev_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        valid_r    <= '0;
        fill_cnt_r <= init_cnt_r;
        fill_dur_r <= init_dur_r;
      end else if (cmd.modify && wr_en) begin
        valid_r[addr_r] <= 1'b1;
      end
      if (cmd.start_set) begin
        prev_idx_r  <= cur_idx_r;
        prev_time_r <= '0;
      end else if (cmd.step_set) begin
        prev_idx_r  <= cur_idx_r;
        prev_time_r <= now_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_tuser;
      net_r     <= in_tdata[63:0];
      now_r     <= in_tdata[111:64];
      oi_r      <= in_tdata[115:112];
      di_r      <= in_tdata[119:116];
      add_cnt_r <= in_tdata[151:120];
      add_dur_r <= in_tdata[199:152];
      mask_w_r  <= mask_r;
      cur_idx_r <= '0;
      obs_cnt_r <= '0;
      rec_r     <= 1'b0;
      cnt_r     <= '0;
      tot_r     <= '0;
    end
    if (cmd.obs_step) begin
      cur_idx_r[obs_cnt_r] <= obs_bit;
      mask_w_r             <= mask_w_r & ~low_bit;
      obs_cnt_r            <= obs_cnt_r + 1'b1;
    end
    if (cmd.addr_set) begin
      addr_r <= {oi_r, di_r};
    end
    if (cmd.step_set) begin
      addr_r    <= {prev_idx_r, cur_idx_r};
      add_cnt_r <= COUNT_BITS'(1);
      add_dur_r <= dt;
      rec_r     <= 1'b1;
    end
    if (cmd.mem_rd) begin
      rd_cnt_r <= mem_cnt[addr_r];
      rd_dur_r <= mem_dur[addr_r];
      rd_vld_r <= valid_r[addr_r];
    end
    if (cmd.modify) begin
      cnt_r <= res_cnt;
      tot_r <= res_dur;
      if (wr_en) begin
        mem_cnt[addr_r] <= new_cnt;
        mem_dur[addr_r] <= new_dur;
      end
    end
    if (cmd.out_load) begin
      out_user_r <= rec_r;
      out_data_r <= {(OUT_DATA_BITS - OUT_USED_BITS)'(0), mean, tot_r, cnt_r, prev_idx_r};
    end
  end

  otm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (tot_r),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign mean = (cnt_r == '0) ? tot_r : div_q;

  assign stat.op       = op_r;
  assign stat.obs_last = (obs_cnt_r == OBS_CW'(OBS_BITS - 1));
  assign stat.changed  = (cur_idx_r != prev_idx_r);
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.div_busy = div_busy;
  assign stat.out_free = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ sv/otm_ctl.sv @@
// ----------------------------------------------------------------------------
// otm_ctl: observed transition matrix controller
// Sequences capture, clear, observation, table read-modify-write, divide and output.
// ----------------------------------------------------------------------------
module otm_ctl
  import otm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  otm_stat_t stat,
  output otm_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_OBS    = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_READ   = 4'd4;
  localparam logic [3:0] S_MOD    = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.op)
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_OUT;
          end
          OP_START, OP_STEP: state_nxt = S_OBS;
          OP_MERGE, OP_READ: begin
            cmd.addr_set = 1'b1;
            state_nxt    = S_READ;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_OBS: begin
        cmd.obs_step = 1'b1;
        if (stat.obs_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.op == OP_START) begin
          cmd.start_set = 1'b1;
          state_nxt     = S_OUT;
        end else if (stat.changed) begin
          cmd.step_set = 1'b1;
          state_nxt    = S_READ;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_MOD;
      end
      S_MOD: begin
        cmd.modify = 1'b1;
        state_nxt  = S_DSTART;
      end
      S_DSTART: begin
        if (stat.cnt_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

@@ sv/observed_transition_matrix.sv @@
// ----------------------------------------------------------------------------
// observed_transition_matrix: transition count and dwell time table
// Clear goes straight to the output; start and step first observe the state
// bits; a recorded step, merge and read access one entry, and a nonzero count
// adds a serial divide (one quotient bit per cycle). One item at a time: the next
// beat is taken the cycle after the result loads; a held result stalls input.
// Reset is synchronous; table reads zero after reset through per-entry valid bits.
// ----------------------------------------------------------------------------
module observed_transition_matrix
  import otm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // network_state, time_now, origin_index, destination_index, add_count,
  // add_duration
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // op
  input  logic [OP_BITS-1:0]       in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // state_index, entry_count, total_duration, mean_duration, zero pad
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // recorded
  output logic [0:0]               out_tuser,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_wdata
);

  otm_cmd_t  cmd;
  otm_stat_t stat;

  otm_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  otm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("controller stayed idle after an accepted beat");

  a_div_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && stat.div_busy))
    else $error("divider running while controller idle");

  a_recorded_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[35:4] != 32'd0))
    else $error("recorded transition with zero count");

endmodule
